/* sv/dfrt_pkg.sv */
// Package: payload types, constants and status codes of the reassembly tracker.
`default_nettype none
package dfrt_pkg;
    localparam int SLOTS = 8;
    localparam int SLOT_W = 3;
    localparam int MAX_FRAGMENTS = 64;
    localparam int MAX_DATAGRAM_BYTES = 2048;
    localparam logic [11:0] HDR_BYTES = 12'd26;
    localparam logic [31:0] MAGIC_VALUE = 32'h4643414D;
    localparam logic [7:0] KEY_BIT = 8'h01;
    localparam logic [16:0] SUM_MAX = 17'd131071;
    localparam logic [15:0] TIMEOUT_RESET = 16'd250;

    localparam logic [3:0] ST_TICK = 4'd0;
    localparam logic [3:0] ST_STORED = 4'd1;
    localparam logic [3:0] ST_COMPLETE = 4'd2;
    localparam logic [3:0] ST_DUP = 4'd3;
    localparam logic [3:0] ST_SHORT = 4'd4;
    localparam logic [3:0] ST_BAD_HDR = 4'd5;
    localparam logic [3:0] ST_BAD_IDX = 4'd6;
    localparam logic [3:0] ST_MISMATCH = 4'd7;
    localparam logic [3:0] ST_TOO_MANY = 4'd8;
    localparam logic [3:0] ST_FULL = 4'd9;

    typedef struct packed {
        logic        kind;
        logic [11:0] datagram_length;
        logic [31:0] magic_word;
        logic [7:0]  version_byte;
        logic [7:0]  flag_byte;
        logic [31:0] frame_number;
        logic [15:0] fragment_index;
        logic [15:0] fragment_total;
        logic [63:0] capture_time_us;
    } t_in_beat;

    typedef struct packed {
        logic [3:0]  status;
        logic [31:0] done_frame_number;
        logic        done_keyframe;
        logic [63:0] done_time_us;
        logic [16:0] done_payload_bytes;
        logic [6:0]  done_fragment_total;
        logic [3:0]  expired_count;
    } t_out_beat;

    // one slot's record as held in the slot memory
    typedef struct packed {
        logic [31:0] frame_number;
        logic        keyframe;
        logic [63:0] time_us;
        logic [6:0]  fragment_total;
        logic [6:0]  received_count;
        logic [63:0] seen_map;
        logic [16:0] byte_sum;
    } t_slot_rec;
endpackage
`default_nettype wire

/* sv/dfrt_slot_ram.sv */
// Slot record memory: one write port, one registered read port.
`default_nettype none
module dfrt_slot_ram
    import dfrt_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [SLOT_W-1:0] i_waddr,
    input  wire t_slot_rec         i_wdata,
    input  wire logic [SLOT_W-1:0] i_raddr,
    output t_slot_rec              o_rdata
);
    t_slot_rec r_mem [SLOTS];

    // write, and registered read (a same-address write returns the old record)
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

/* sv/datagram_fragment_reassembly_tracker.sv */
// Top level: fragment reassembly tracker with slot memory and control sequencer.
//
//  channel | direction | handshake     | payload
//  in      | input     | valid / stall | t_in_beat
//  out     | output    | valid / stall | t_out_beat
//  cfg     | input     | valid / ready | timeout_ticks (16 bit)
//
// A stored datagram passes through a scan of every slot for ages and frame
// numbers (tags and touch times live in flip-flops), then a memory read, a modify
// step and the write back. A tick, a header reject or a full table skips the modify.
// Reset is synchronous, active low; slot contents need no clearing.
// A finished result waits in the output register; the next item waits while
// that result is stalled.
`default_nettype none
module datagram_fragment_reassembly_tracker
    import dfrt_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_in_valid,
    output logic           o_in_stall,
    input  wire t_in_beat  i_in_data,
    output logic           o_out_valid,
    input  wire logic      i_out_stall,
    output t_out_beat      o_out_data,
    input  wire logic      i_cfg_valid,
    output logic           o_cfg_ready,
    input  wire logic [15:0] i_cfg_data
);
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SCAN = 3'd1;
    localparam logic [2:0] S_READ = 3'd2;
    localparam logic [2:0] S_MOD  = 3'd3;
    localparam logic [2:0] S_OUT  = 3'd4;

    logic [2:0]        r_state;
    t_in_beat          r_item;
    logic [15:0]       r_timeout;
    logic [31:0]       r_tick;
    logic [SLOTS-1:0]  r_valid;
    logic [31:0]       r_tag   [SLOTS];
    logic [31:0]       r_touch [SLOTS];
    logic [SLOT_W-1:0] r_idx;
    logic [3:0]        r_expired;
    logic              r_hit;
    logic [SLOT_W-1:0] r_hit_slot;
    logic              r_free;
    logic [SLOT_W-1:0] r_free_slot;
    logic [SLOT_W-1:0] r_slot;
    logic              r_new;
    t_out_beat         r_res;
    logic              r_out_valid;
    t_slot_rec         r_wrec;
    logic              r_we;

    t_slot_rec         w_rdata;
    logic [SLOT_W-1:0] w_raddr;
    logic              w_accept;
    logic              w_age_out;
    logic              w_valid_now;
    logic [3:0]        w_status_pre;
    logic [11:0]       w_len;
    logic [15:0]       w_idx;
    logic [15:0]       w_tot;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = (r_state != S_IDLE) || (r_out_valid && i_out_stall);
    assign w_accept    = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_res;

    assign w_len = r_item.datagram_length;
    assign w_idx = r_item.fragment_index;
    assign w_tot = r_item.fragment_total;
    assign w_age_out = r_valid[r_idx] &&
                       ((r_tick - r_touch[r_idx]) > {16'd0, r_timeout});
    assign w_valid_now = r_valid[r_idx] && !w_age_out;

    // address the chosen slot while deciding, so its record is ready for modify
    assign w_raddr = (r_state == S_READ) ? (r_hit ? r_hit_slot : r_free_slot) : r_slot;

    // header checks in model order
    always_comb begin
        if (w_len < HDR_BYTES || w_len > 12'(MAX_DATAGRAM_BYTES)) begin
            w_status_pre = ST_SHORT;
        end else if (r_item.magic_word != MAGIC_VALUE || r_item.version_byte != 8'd0) begin
            w_status_pre = ST_BAD_HDR;
        end else if (w_tot == 16'd0 || w_idx >= w_tot) begin
            w_status_pre = ST_BAD_IDX;
        end else if (w_tot > 16'(MAX_FRAGMENTS)) begin
            w_status_pre = ST_TOO_MANY;
        end else begin
            w_status_pre = ST_STORED;
        end
    end

    dfrt_slot_ram u_ram (
        .i_clk   (i_clk),
        .i_we    (r_we),
        .i_waddr (r_slot),
        .i_wdata (r_wrec),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // modify: merge the fragment into the record
    t_slot_rec   w_base;
    t_slot_rec   w_mod;
    logic [63:0] w_bit;
    logic        w_dup;
    logic [17:0] w_sum;
    always_comb begin
        w_base = w_rdata;
        if (r_new) begin
            w_base.frame_number   = r_item.frame_number;
            w_base.keyframe       = |(r_item.flag_byte & KEY_BIT);
            w_base.time_us        = r_item.capture_time_us;
            w_base.fragment_total = w_tot[6:0];
            w_base.received_count = 7'd0;
            w_base.seen_map       = 64'd0;
            w_base.byte_sum       = 17'd0;
        end
        w_bit = 64'd1 << w_idx[5:0];
        w_dup = |(w_base.seen_map & w_bit);
        w_sum = {1'b0, w_base.byte_sum} + {6'd0, w_len - HDR_BYTES};
        w_mod = w_base;
        if (!w_dup) begin
            w_mod.seen_map       = w_base.seen_map | w_bit;
            w_mod.received_count = w_base.received_count + 7'd1;
            w_mod.byte_sum       = (w_sum > {1'b0, SUM_MAX}) ? SUM_MAX : w_sum[16:0];
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_timeout   <= TIMEOUT_RESET;
            r_tick      <= 32'd0;
            r_valid     <= '0;
            r_out_valid <= 1'b0;
            r_we        <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_timeout <= i_cfg_data;
            end
            if (r_out_valid && !i_out_stall && r_state != S_OUT) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_item    <= i_in_data;
                        r_idx     <= '0;
                        r_expired <= 4'd0;
                        r_hit     <= 1'b0;
                        r_free    <= 1'b0;
                        if (i_in_data.kind) begin
                            r_tick <= r_tick + 32'd1;
                        end
                        r_state <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    // expire this slot if aged out, then look for a match or a free slot
                    if (w_age_out) begin
                        r_valid[r_idx] <= 1'b0;
                        if (r_expired != 4'd15) begin
                            r_expired <= r_expired + 4'd1;
                        end
                    end
                    if (w_valid_now && r_tag[r_idx] == r_item.frame_number && !r_hit) begin
                        r_hit      <= 1'b1;
                        r_hit_slot <= r_idx;
                    end
                    if (!w_valid_now && !r_free) begin
                        r_free      <= 1'b1;
                        r_free_slot <= r_idx;
                    end
                    r_idx <= r_idx + 1'b1;
                    if (r_idx == SLOT_W'(SLOTS - 1)) begin
                        r_state <= S_READ;
                    end
                end
                S_READ: begin
                    r_res.done_keyframe       <= 1'b0;
                    r_res.done_time_us        <= 64'd0;
                    r_res.done_payload_bytes  <= 17'd0;
                    r_res.done_fragment_total <= 7'd0;
                    r_res.expired_count       <= r_expired;
                    r_res.done_frame_number   <= r_item.kind ? 32'd0 : r_item.frame_number;
                    if (r_item.kind) begin
                        r_res.status <= ST_TICK;
                        r_state      <= S_OUT;
                    end else begin
                        if (w_status_pre != ST_STORED) begin
                            r_res.status <= w_status_pre;
                            r_state      <= S_OUT;
                        end else if (r_hit) begin
                            r_slot  <= r_hit_slot;
                            r_new   <= 1'b0;
                            r_state <= S_MOD;
                        end else if (r_free) begin
                            r_slot  <= r_free_slot;
                            r_new   <= 1'b1;
                            r_state <= S_MOD;
                        end else begin
                            r_res.status <= ST_FULL;
                            r_state      <= S_OUT;
                        end
                    end
                end
                S_MOD: begin
                    // memory data is ready this cycle
                    if (!r_new && w_rdata.fragment_total != w_tot[6:0]) begin
                        r_valid[r_slot] <= 1'b0;
                        r_res.status    <= ST_MISMATCH;
                        r_we            <= 1'b0;
                    end else begin
                        r_tag[r_slot]   <= r_item.frame_number;
                        r_touch[r_slot] <= r_tick;
                        r_wrec          <= w_mod;
                        r_we            <= 1'b1;
                        r_res.done_keyframe       <= w_mod.keyframe;
                        r_res.done_time_us        <= w_mod.time_us;
                        r_res.done_payload_bytes  <= w_mod.byte_sum;
                        r_res.done_fragment_total <= w_mod.fragment_total;
                        if (w_dup) begin
                            r_res.status    <= ST_DUP;
                            r_valid[r_slot] <= 1'b1;
                        end else if (w_mod.received_count == w_mod.fragment_total) begin
                            r_res.status    <= ST_COMPLETE;
                            r_valid[r_slot] <= 1'b0;
                        end else begin
                            r_res.status    <= ST_STORED;
                            r_valid[r_slot] <= 1'b1;
                        end
                    end
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    // wait for the output register to be free
                    r_we <= 1'b0;
                    if (!r_out_valid || !i_out_stall) begin
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

/* verif/datagram_fragment_reassembly_tracker_tb.sv */
// Testbench: reassembly tracker checked against a scoreboard predictor under random idling.
`default_nettype none
module datagram_fragment_reassembly_tracker_tb;
    import dfrt_pkg::*;

    // frame reassembly predictor and queue of pending result beats
    class reassembly_scoreboard;
        logic [15:0] timeout_ticks;
        bit          slot_busy [SLOTS];
        logic [31:0] slot_frame [SLOTS];
        logic        slot_key [SLOTS];
        logic [63:0] slot_time [SLOTS];
        logic [6:0]  slot_total [SLOTS];
        logic [6:0]  slot_count [SLOTS];
        logic [63:0] slot_seen [SLOTS];
        logic [16:0] slot_sum [SLOTS];
        logic [31:0] slot_touch [SLOTS];
        logic [31:0] tick_now;
        t_out_beat   pending_beats [$];
        int          errors;

        function new();
            timeout_ticks = TIMEOUT_RESET;
            tick_now = 0;
            errors = 0;
            foreach (slot_busy[i]) slot_busy[i] = 0;
        endfunction

        // predict the beat caused by one accepted input
        function void note_input(t_in_beat b);
            t_out_beat r;
            logic [31:0] age;
            logic [17:0] sum;
            logic [3:0] expired;
            int s;
            bit dup;
            r = '0;
            expired = 0;
            s = -1;
            if (b.kind) tick_now = tick_now + 32'd1;
            for (int i = 0; i < SLOTS; i++) begin
                age = tick_now - slot_touch[i];
                if (slot_busy[i] && age > {16'd0, timeout_ticks}) begin
                    slot_busy[i] = 0;
                    if (expired != 4'd15) expired = expired + 4'd1;
                end
            end
            r.expired_count = expired;
            if (b.kind) begin
                r.status = ST_TICK;
                pending_beats.push_back(r);
                return;
            end
            r.done_frame_number = b.frame_number;
            if (b.datagram_length < HDR_BYTES || b.datagram_length > MAX_DATAGRAM_BYTES)
                r.status = ST_SHORT;
            else if (b.magic_word != MAGIC_VALUE || b.version_byte != 0)
                r.status = ST_BAD_HDR;
            else if (b.fragment_total == 0 || b.fragment_index >= b.fragment_total)
                r.status = ST_BAD_IDX;
            else if (b.fragment_total > MAX_FRAGMENTS)
                r.status = ST_TOO_MANY;
            if (r.status != ST_TICK) begin
                pending_beats.push_back(r);
                return;
            end
            for (int i = 0; i < SLOTS; i++)
                if (s < 0 && slot_busy[i] && slot_frame[i] == b.frame_number) s = i;
            if (s >= 0) begin
                if ({9'd0, slot_total[s]} != b.fragment_total) begin
                    slot_busy[s] = 0;
                    r.status = ST_MISMATCH;
                    pending_beats.push_back(r);
                    return;
                end
            end else begin
                for (int i = 0; i < SLOTS; i++) if (s < 0 && !slot_busy[i]) s = i;
                if (s < 0) begin
                    r.status = ST_FULL;
                    pending_beats.push_back(r);
                    return;
                end
                slot_busy[s] = 1;
                slot_frame[s] = b.frame_number;
                slot_key[s] = (b.flag_byte & KEY_BIT) != 0;
                slot_time[s] = b.capture_time_us;
                slot_total[s] = b.fragment_total[6:0];
                slot_count[s] = 7'd0;
                slot_seen[s] = 64'd0;
                slot_sum[s] = 17'd0;
            end
            slot_touch[s] = tick_now;
            dup = slot_seen[s][b.fragment_index[5:0]];
            if (!dup) begin
                sum = {1'b0, slot_sum[s]} + 18'(b.datagram_length - HDR_BYTES);
                slot_seen[s][b.fragment_index[5:0]] = 1'b1;
                slot_count[s] = slot_count[s] + 7'd1;
                slot_sum[s] = sum > {1'b0, SUM_MAX} ? SUM_MAX : sum[16:0];
            end
            r.done_keyframe = slot_key[s];
            r.done_time_us = slot_time[s];
            r.done_payload_bytes = slot_sum[s];
            r.done_fragment_total = slot_total[s];
            if (!dup && slot_count[s] == slot_total[s]) begin
                slot_busy[s] = 0;
                r.status = ST_COMPLETE;
            end else begin
                r.status = dup ? ST_DUP : ST_STORED;
            end
            pending_beats.push_back(r);
        endfunction

        // compare one accepted result beat with the oldest prediction
        function void check_result(t_out_beat a);
            t_out_beat e;
            if (pending_beats.size() == 0) begin
                $error("unexpected result beat status=%0d", a.status);
                errors++;
                return;
            end
            e = pending_beats.pop_front();
            if (a.status != e.status) begin
                $error("status exp %0d got %0d", e.status, a.status); errors++;
            end
            if (a.done_frame_number != e.done_frame_number) begin
                $error("done_frame_number exp %0h got %0h", e.done_frame_number,
                       a.done_frame_number); errors++;
            end
            if (a.done_keyframe != e.done_keyframe) begin
                $error("done_keyframe exp %0d got %0d", e.done_keyframe, a.done_keyframe);
                errors++;
            end
            if (a.done_time_us != e.done_time_us) begin
                $error("done_time_us exp %0h got %0h", e.done_time_us, a.done_time_us);
                errors++;
            end
            if (a.done_payload_bytes != e.done_payload_bytes) begin
                $error("done_payload_bytes exp %0d got %0d", e.done_payload_bytes,
                       a.done_payload_bytes); errors++;
            end
            if (a.done_fragment_total != e.done_fragment_total) begin
                $error("done_fragment_total exp %0d got %0d", e.done_fragment_total,
                       a.done_fragment_total); errors++;
            end
            if (a.expired_count != e.expired_count) begin
                $error("expired_count exp %0d got %0d", e.expired_count, a.expired_count);
                errors++;
            end
        endfunction
    endclass

    localparam int CYCLE_LIMIT = 2000000;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    t_in_beat    i_in_data;
    logic        o_out_valid;
    logic        i_out_stall;
    t_out_beat   o_out_data;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [15:0] i_cfg_data;

    reassembly_scoreboard sb;
    int          cycle_count;
    bit          out_idle_enable;
    logic [31:0] frame_base;

    datagram_fragment_reassembly_tracker u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_data (o_out_data),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_data (i_cfg_data)
    );

    always begin
        i_clk = 1'b1; #1;
        i_clk = 1'b0; #1;
    end

    function automatic int gap_len();
        if ($urandom_range(0, 2) == 0) return 0;
        if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
        return $urandom_range(0, 3);
    endfunction

    // receive side: random stall, check each accepted beat
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end else if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) sb.check_result(o_out_data);
            i_out_stall <= out_idle_enable ? ($urandom_range(0, 3) == 0) : 1'b0;
        end
    end

    // send one beat after an idle gap, hold until accepted
    task automatic send_beat(t_in_beat b);
        repeat (gap_len() + 1) @(posedge i_clk);
        i_in_valid <= 1'b1;
        i_in_data <= b;
        do @(posedge i_clk); while (o_in_stall);
        sb.note_input(b);
        i_in_valid <= 1'b0;
    endtask

    task automatic write_timeout(logic [15:0] val);
        while (sb.pending_beats.size() != 0) @(posedge i_clk);
        repeat (SLOTS + 8) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.timeout_ticks = val;
        i_cfg_valid <= 1'b0;
    endtask

    function automatic t_in_beat good_frag(logic [31:0] fn, int idx, int tot);
        t_in_beat b;
        b.kind = 1'b0;
        b.datagram_length = 12'($urandom_range(26, 2048));
        b.magic_word = MAGIC_VALUE;
        b.version_byte = 8'd0;
        b.flag_byte = 8'($urandom);
        b.frame_number = fn;
        b.fragment_index = 16'(idx);
        b.fragment_total = 16'(tot);
        b.capture_time_us = {$urandom, $urandom};
        return b;
    endfunction

    function automatic t_in_beat tick_beat();
        t_in_beat b;
        b = $bits(t_in_beat)'({$urandom, $urandom, $urandom, $urandom, $urandom,
                                $urandom, $urandom});
        b.kind = 1'b1;
        return b;
    endfunction

    function automatic t_in_beat noise_beat();
        t_in_beat b;
        b = $bits(t_in_beat)'({$urandom, $urandom, $urandom, $urandom, $urandom,
                                $urandom, $urandom});
        b.kind = 1'b0;
        if ($urandom_range(0, 1)) b.magic_word = MAGIC_VALUE;
        if ($urandom_range(0, 1)) b.version_byte = 8'd0;
        if ($urandom_range(0, 1)) b.datagram_length = 12'($urandom_range(0, 2100));
        return b;
    endfunction

    // one frame sent in shuffled order with optional duplicates, drops, a wrong total and ticks
    task automatic send_frame(logic [31:0] fn, int tot);
        int order [$];
        t_in_beat b;
        for (int i = 0; i < tot; i++) order.push_back(i);
        order.shuffle();
        if ($urandom_range(0, 4) == 0) order.push_back($urandom_range(0, tot - 1));
        if ($urandom_range(0, 6) == 0) void'(order.pop_back());
        foreach (order[k]) begin
            b = good_frag(fn, order[k], tot);
            if (k == 0 && $urandom_range(0, 9) == 0) b.fragment_total = 16'($urandom_range(1, 64));
            if ($urandom_range(0, 7) == 0) send_beat(tick_beat());
            send_beat(b);
        end
    endtask

    task automatic run_random(int count);
        int sent;
        int tot;
        sent = 0;
        while (sent < count) begin
            case ($urandom_range(0, 9))
                0, 1: begin send_beat(noise_beat()); sent++; end
                2: begin send_beat(tick_beat()); sent++; end
                default: begin
                    tot = ($urandom_range(0, 15) == 0) ? $urandom_range(1, 64)
                                                       : $urandom_range(1, 6);
                    send_frame(frame_base + 32'($urandom_range(0, 15)), tot);
                    sent += tot;
                end
            endcase
        end
    endtask

    initial begin
        t_in_beat b;
        sb = new();
        cycle_count = 0;
        out_idle_enable = 1'b0;
        frame_base = $urandom;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in_data = '0;
        i_out_stall = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_data = '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: header checks at their extremes
        b = good_frag(32'hFFFF_FFFF, 0, 1); b.datagram_length = 12'd25; send_beat(b);
        b = good_frag(32'd0, 0, 1); b.datagram_length = 12'd2049; send_beat(b);
        b = good_frag(32'd1, 0, 1); b.datagram_length = 12'hFFF; send_beat(b);
        b = good_frag(32'd2, 0, 1); b.magic_word = ~MAGIC_VALUE; send_beat(b);
        b = good_frag(32'd3, 0, 1); b.version_byte = 8'hFF; send_beat(b);
        b = good_frag(32'd4, 0, 0); send_beat(b);
        b = good_frag(32'd5, 16'hFFFF, 16'hFFFF); send_beat(b);
        b = good_frag(32'd6, 0, 65); send_beat(b);
        // single fragment frame with header-only length, then a maximal last fragment of 64
        b = good_frag(32'd7, 0, 1); b.datagram_length = 12'd26; send_beat(b);
        b = good_frag(32'd8, 63, 64); b.datagram_length = 12'd2048; b.flag_byte = 8'hFF;
        send_beat(b);
        // duplicate header-only fragment, then count mismatch
        b = good_frag(32'd9, 0, 3); b.datagram_length = 12'd26; send_beat(b);
        send_beat(b);
        b = good_frag(32'd9, 1, 4); send_beat(b);
        // fill the table and overflow it
        for (int i = 0; i < SLOTS + 1; i++) send_beat(good_frag(32'd100 + 32'(i), 0, 2));
        send_beat(tick_beat());

        // expiry with a timeout of one tick, all slots full
        write_timeout(16'd1);
        send_beat(tick_beat());
        send_beat(tick_beat());
        send_beat(tick_beat());

        out_idle_enable = 1'b1;
        run_random(280);
        write_timeout(16'hFFFF);
        run_random(280);
        write_timeout(16'd3);
        run_random(320);
        write_timeout(TIMEOUT_RESET);
        // largest payload sum: all 64 fragments of one frame at maximal length
        for (int i = 0; i < 64; i++) begin
            b = good_frag(32'hABCD_0000, i, 64); b.datagram_length = 12'd2048;
            send_beat(b);
        end
        run_random(220);

        while (sb.pending_beats.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending_beats.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end
endmodule
`default_nettype wire

/* files.f */
sv/dfrt_pkg.sv
sv/dfrt_slot_ram.sv
sv/datagram_fragment_reassembly_tracker.sv
verif/datagram_fragment_reassembly_tracker_tb.sv
